/* hdl/lsc_pkg.sv */
// Package for the linear softmax classifier: item types, opcodes, exp table.
// No dependencies.
package lsc_pkg;

  localparam logic [1:0] OP_WEIGHT = 2'd0;
  localparam logic [1:0] OP_BIAS   = 2'd1;
  localparam logic [1:0] OP_PIXEL  = 2'd2;

  localparam logic signed [39:0] ACC_MAX = 40'sh7F_FFFF_FFFF;
  localparam logic signed [39:0] ACC_MIN = 40'sh80_0000_0000;
  localparam logic [31:0] LOG2E_SCALE = 32'd777578417;
  localparam logic [23:0] D_CLAMP = 24'hFF_FFFF;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [3:0]         class_index;
    logic [9:0]         pixel_index;
    logic signed [15:0] coef_value;
    logic signed [31:0] bias_value;
    logic [7:0]         pixel_value;
    logic               last_pixel;
  } in_item_t;

  typedef struct packed {
    logic [3:0]         class_id;
    logic signed [39:0] logit;
    logic [15:0]        probability;
    logic [3:0]         predicted_class;
    logic               last_result;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MAC_RD, ST_MAC_ADD, ST_LOGIT, ST_MAX, ST_EXP_MUL, ST_EXP_INT,
    ST_EXP_SUM, ST_DIV, ST_ARGMAX, ST_EMIT
  } state_t;

  function automatic logic [16:0] exp2_tab(input logic [4:0] k);
    logic [16:0] v;
    case (k)
      5'd0: v = 17'd65536;   5'd1: v = 17'd62757;   5'd2: v = 17'd60097;
      5'd3: v = 17'd57549;   5'd4: v = 17'd55109;   5'd5: v = 17'd52773;
      5'd6: v = 17'd50535;   5'd7: v = 17'd48393;   5'd8: v = 17'd46341;
      5'd9: v = 17'd44376;   5'd10: v = 17'd42495;  5'd11: v = 17'd40693;
      5'd12: v = 17'd38968;  5'd13: v = 17'd37316;  5'd14: v = 17'd35734;
      5'd15: v = 17'd34219;  5'd16: v = 17'd32768;
      default: v = 17'd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [39:0] sat40(input logic signed [41:0] v);
    logic signed [39:0] r;
    if (v > 42'(ACC_MAX)) r = ACC_MAX;
    else if (v < 42'(ACC_MIN)) r = ACC_MIN;
    else r = v[39:0];
    return r;
  endfunction

endpackage

/* hdl/lsc_front.sv */
// Front end: accepts items, drops meaningless ones, and queues the rest.
// Depends on lsc_pkg.
module lsc_front import lsc_pkg::*; #(
  parameter int NUM_INPUTS  = 784,
  parameter int NUM_CLASSES = 10,
  parameter int DEPTH       = 4
) (
  input  logic     clk,
  input  logic     rst,
  input  in_item_t in_item,
  input  logic     push,
  output logic     full,
  output in_item_t q_item,
  output logic     q_valid,
  input  logic     q_take
);
  localparam int AW = $clog2(DEPTH);
  in_item_t mem [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [AW:0]   count;
  logic keep, do_push, do_pop;

  // Weight and bias writes to bad addresses and unused opcodes are dropped.
  always_comb begin
    case (in_item.opcode)
      OP_WEIGHT: keep = (32'(in_item.class_index) < NUM_CLASSES) &&
                        (32'(in_item.pixel_index) < NUM_INPUTS);
      OP_BIAS:   keep = 32'(in_item.class_index) < NUM_CLASSES;
      OP_PIXEL:  keep = 1'b1;
      default:   keep = 1'b0;
    endcase
  end

  assign full    = (count == (AW+1)'(DEPTH));
  assign do_push = push && !full && keep;
  assign q_valid = (count != '0);
  assign do_pop  = q_take && q_valid;
  assign q_item  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= in_item;
    if (rst) begin
      wr_ptr <= '0; rd_ptr <= '0; count <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == AW'(DEPTH-1)) ? '0 : wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= (rd_ptr == AW'(DEPTH-1)) ? '0 : rd_ptr + 1'b1;
      count <= count + (AW+1)'(do_push) - (AW+1)'(do_pop);
    end
  end
endmodule

/* hdl/lsc_divider.sv */
// Restoring divider, one quotient bit per cycle: (num << 16 + s/2) / s.
// Depends on lsc_pkg.
module lsc_divider import lsc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [16:0] e_val,
  input  logic [20:0] sum,
  output logic        done,
  output logic [15:0] prob
);
  logic [33:0] dividend;
  logic [21:0] rem;
  logic [33:0] quo;
  logic [5:0]  cnt;
  logic        busy;
  logic [21:0] trial;

  assign trial = {rem[20:0], dividend[33]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0; done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        dividend <= {e_val, 16'd0} + 34'(sum[20:1]);
        rem <= '0; quo <= '0; cnt <= 6'd34; busy <= 1'b1;
      end else if (busy) begin
        dividend <= {dividend[32:0], 1'b0};
        if (trial >= {1'b0, sum}) begin
          rem <= trial - {1'b0, sum}; quo <= {quo[32:0], 1'b1};
        end else begin
          rem <= trial; quo <= {quo[32:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == 6'd1) begin
          busy <= 1'b0; done <= 1'b1;
        end
      end
    end
  end

  assign prob = (quo > 34'd65535) ? 16'hFFFF : quo[15:0];
endmodule

/* hdl/lsc_back.sv */
// Back end: weight and bias stores, shared multiply-accumulate, softmax sequencer.
// Depends on lsc_pkg and lsc_divider.
module lsc_back import lsc_pkg::*; #(
  parameter int NUM_INPUTS  = 784,
  parameter int NUM_CLASSES = 10,
  parameter int WEIGHT_BITS = 16
) (
  input  logic      clk,
  input  logic      rst,
  input  in_item_t  q_item,
  input  logic      q_valid,
  output logic      q_take,
  output out_item_t res,
  output logic      res_valid,
  input  logic      res_take
);
  localparam int CW = $clog2(NUM_CLASSES);
  localparam int WDEPTH = NUM_CLASSES * NUM_INPUTS;
  localparam int WA = $clog2(WDEPTH);

  logic signed [WEIGHT_BITS-1:0] wmem [WDEPTH];
  logic signed [31:0] bias [NUM_CLASSES];
  logic signed [39:0] acc  [NUM_CLASSES];
  logic [16:0] ev [NUM_CLASSES];
  logic [15:0] pv [NUM_CLASSES];

  state_t state, state_next;
  logic [CW-1:0] cls;
  logic [WA-1:0] base;
  logic signed [WEIGHT_BITS-1:0] wrd;
  logic signed [WEIGHT_BITS+8:0] prod;
  logic [7:0] pix;
  logic [9:0] pidx;
  logic last;
  logic signed [39:0] mx;
  logic [55:0] ymul;
  logic [20:0] sum;
  logic [CW-1:0] best;
  logic div_start, div_done, div_run;
  logic [15:0] div_prob;

  lsc_divider u_div (.clk, .rst, .start(div_start), .e_val(ev[cls]), .sum,
                     .done(div_done), .prob(div_prob));

  logic [23:0] dclamp;
  logic [40:0] dfull;
  logic [23:0] y;
  logic [4:0]  kk;
  logic [16:0] ta, tb, interp;
  logic [28:0] dr;
  always_comb begin
    dfull  = 41'(mx) - 41'(acc[cls]);
    dclamp = (dfull > 41'(D_CLAMP)) ? D_CLAMP : dfull[23:0];
    y      = ymul[55:32];
    kk     = {1'b0, y[15:12]};
    ta     = exp2_tab(kk);
    tb     = exp2_tab(kk + 5'd1);
    dr     = 29'(ta - tb) * 29'(y[11:0]);
    interp = ta - dr[28:12];
  end

  // Every item leaves the queue as the idle sequencer starts it; a pixel
  // item's fields are held in registers for its walk over the classes.
  assign q_take = (state == ST_IDLE) && q_valid;
  assign res_valid = (state == ST_EMIT);
  assign res = '{class_id: 4'(cls), logit: acc[cls], probability: pv[cls],
                 predicted_class: 4'(best),
                 last_result: (32'(cls) == NUM_CLASSES-1)};

  always_comb begin
    state_next = state;
    div_start = 1'b0;
    case (state)
      ST_IDLE:
        if (q_valid && q_item.opcode == OP_PIXEL) begin
          state_next = (32'(q_item.pixel_index) < NUM_INPUTS) ? ST_MAC_RD :
                       (q_item.last_pixel ? ST_LOGIT : ST_IDLE);
        end
      ST_MAC_RD:  state_next = ST_MAC_ADD;
      ST_MAC_ADD:
        if (32'(cls) == NUM_CLASSES-1) state_next = last ? ST_LOGIT : ST_IDLE;
        else state_next = ST_MAC_RD;
      ST_LOGIT:   if (32'(cls) == NUM_CLASSES-1) state_next = ST_MAX;
      ST_MAX:     if (32'(cls) == NUM_CLASSES-1) state_next = ST_EXP_MUL;
      ST_EXP_MUL: state_next = ST_EXP_INT;
      ST_EXP_INT: state_next = ST_EXP_SUM;
      ST_EXP_SUM:
        if (32'(cls) == NUM_CLASSES-1) state_next = ST_DIV;
        else state_next = ST_EXP_MUL;
      ST_DIV: begin
        // One division per class; the next one starts the cycle after done.
        div_start = !div_run;
        if (div_done && 32'(cls) == NUM_CLASSES-1) state_next = ST_ARGMAX;
      end
      ST_ARGMAX:  if (32'(cls) == NUM_CLASSES-1) state_next = ST_EMIT;
      ST_EMIT:    if (res_take && 32'(cls) == NUM_CLASSES-1) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  // Weight store port: written for weight items, read for the MAC walk.
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && q_valid && q_item.opcode == OP_WEIGHT)
      wmem[WA'(32'(q_item.class_index) * NUM_INPUTS) + WA'(q_item.pixel_index)]
        <= WEIGHT_BITS'(q_item.coef_value);
    wrd <= wmem[base + WA'(pidx)];
    if (state == ST_IDLE && q_valid && q_item.opcode == OP_BIAS)
      bias[CW'(q_item.class_index)] <= q_item.bias_value;
  end

  always_ff @(posedge clk) begin
    state <= rst ? ST_IDLE : state_next;
    if (rst) begin
      cls <= '0; base <= '0; div_run <= 1'b0;
      for (int i = 0; i < NUM_CLASSES; i++) acc[i] <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          cls <= '0; base <= '0;
          pix <= q_item.pixel_value; pidx <= q_item.pixel_index;
          last <= q_item.last_pixel;
          mx <= ACC_MIN; sum <= '0; best <= '0;
        end
        ST_MAC_RD: ;
        ST_MAC_ADD: begin
          acc[cls] <= sat40(42'(acc[cls]) + 42'(prod));
          base <= base + WA'(NUM_INPUTS);
          cls <= (32'(cls) == NUM_CLASSES-1) ? '0 : cls + 1'b1;
        end
        ST_LOGIT: begin
          acc[cls] <= sat40(42'(acc[cls]) + 42'(bias[cls]));
          cls <= (32'(cls) == NUM_CLASSES-1) ? '0 : cls + 1'b1;
        end
        ST_MAX: begin
          if (acc[cls] > mx) mx <= acc[cls];
          cls <= (32'(cls) == NUM_CLASSES-1) ? '0 : cls + 1'b1;
        end
        ST_EXP_MUL: ymul <= 56'(dclamp) * 56'(LOG2E_SCALE);
        ST_EXP_INT: ev[cls] <= (y[23:16] >= 8'd17) ? 17'd0 : interp >> y[20:16];
        ST_EXP_SUM: begin
          sum <= sum + 21'(ev[cls]);
          cls <= (32'(cls) == NUM_CLASSES-1) ? '0 : cls + 1'b1;
        end
        ST_DIV:
          if (div_done) begin
            pv[cls] <= div_prob;
            div_run <= 1'b0;
            cls <= (32'(cls) == NUM_CLASSES-1) ? '0 : cls + 1'b1;
          end else if (div_start) begin
            div_run <= 1'b1;
          end
        ST_ARGMAX: begin
          if (pv[cls] > pv[best]) best <= cls;
          cls <= (32'(cls) == NUM_CLASSES-1) ? '0 : cls + 1'b1;
        end
        ST_EMIT:
          if (res_take) begin
            acc[cls] <= '0;
            cls <= (32'(cls) == NUM_CLASSES-1) ? '0 : cls + 1'b1;
          end
        default: ;
      endcase
    end
  end

  assign prod = $signed(wrd) * $signed({1'b0, pix});
endmodule

/* hdl/linear_softmax_classifier_core.sv */
// Top level of the linear softmax classifier.
// Depends on lsc_pkg, lsc_front, lsc_back and lsc_divider.
//
// Usage: input items enter through a queue-style port (push, full) and
// results leave through one (empty, pop). Weight and bias items are stored
// as the idle back end takes them. A pixel item inside the image walks the
// ten classes through one shared multiply-accumulate, a read step and an
// add step per class, after it is taken from the queue; this loop sets the
// throughput of an image.
// After the item marked last_pixel the block adds the biases, finds the
// maximum logit, computes ten exponentials (multiply, interpolate, sum)
// and ten probabilities with a bit-serial divider, picks the first maximum
// and emits NUM_CLASSES result items in class order, the last one flagged
// with last_result.
// A four-entry queue between the front and the back end absorbs input
// while the back end is busy. When the receiver does not pop, the block
// holds the current result and stops taking work; nothing is lost.
// Synchronous reset empties the queue and zeroes the accumulators; the
// weight and bias stores hold no defined values until written.
module linear_softmax_classifier_core import lsc_pkg::*; #(
  parameter int NUM_INPUTS  = 784,
  parameter int NUM_CLASSES = 10,
  parameter int WEIGHT_BITS = 16
) (
  input  logic      clk,
  input  logic      rst,
  input  in_item_t  in_item,
  input  logic      push,
  output logic      full,
  output out_item_t out_item,
  output logic      empty,
  input  logic      pop
);
  in_item_t q_item;
  logic q_valid, q_take, res_valid;

  lsc_front #(.NUM_INPUTS(NUM_INPUTS), .NUM_CLASSES(NUM_CLASSES)) u_front (
    .clk, .rst, .in_item, .push, .full, .q_item, .q_valid, .q_take
  );

  // The back end pops every item as it starts it.
  lsc_back #(.NUM_INPUTS(NUM_INPUTS), .NUM_CLASSES(NUM_CLASSES),
             .WEIGHT_BITS(WEIGHT_BITS)) u_back (
    .clk, .rst, .q_item, .q_valid, .q_take(q_take),
    .res(out_item), .res_valid, .res_take(pop)
  );

  assign empty = !res_valid;
endmodule

/* bench/lsc_result_checker.sv */
`timescale 1ns / 100ps
// Result checker for the linear softmax classifier: watches both item ports,
// predicts the ten per-image results and compares them. Depends on lsc_pkg.
module lsc_result_checker import lsc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  in_item_t  in_item,
  input  logic      push,
  input  logic      full,
  input  out_item_t out_item,
  input  logic      empty,
  input  logic      pop,
  output int        errors,
  output int        outstanding
);

  localparam int CLASSES = 10;
  localparam int PIXELS  = 784;

  localparam logic [16:0] POW2_FRAC [17] = '{
    17'd65536, 17'd62757, 17'd60097, 17'd57549, 17'd55109, 17'd52773,
    17'd50535, 17'd48393, 17'd46341, 17'd44376, 17'd42495, 17'd40693,
    17'd38968, 17'd37316, 17'd35734, 17'd34219, 17'd32768};

  logic signed [15:0] weights [CLASSES][PIXELS];
  logic signed [31:0] biases [CLASSES];
  logic signed [39:0] class_sums [CLASSES];
  out_item_t          results_due [$];

  function automatic logic signed [39:0] clip40(input longint v);
    if (v > longint'(ACC_MAX)) return ACC_MAX;
    if (v < longint'(ACC_MIN)) return ACC_MIN;
    return v[39:0];
  endfunction

  // exp(-d) scaled to 2^16, by a 16-step power-of-two table.
  function automatic longint unsigned decay(input longint unsigned d);
    longint unsigned y, n, k, r, a, b;
    if (d > 64'hFF_FFFF) d = 64'hFF_FFFF;
    y = (d * 64'd777578417) >> 32;
    n = y >> 16;
    if (n >= 17) return 0;
    k = (y >> 12) & 15;
    r = y & 12'hFFF;
    a = POW2_FRAC[k];
    b = POW2_FRAC[k + 1];
    return (a - (((a - b) * r) >> 12)) >> n;
  endfunction

  task automatic close_image();
    logic signed [39:0] logits [CLASSES];
    longint unsigned    ex [CLASSES];
    longint unsigned    prob [CLASSES];
    longint             top;
    longint unsigned    total;
    int                 winner;
    out_item_t          r;
    top = longint'(ACC_MIN);
    total = 0;
    winner = 0;
    for (int c = 0; c < CLASSES; c++) begin
      logits[c] = clip40(longint'(class_sums[c]) + longint'(biases[c]));
      if (longint'(logits[c]) > top) top = logits[c];
    end
    for (int c = 0; c < CLASSES; c++) begin
      ex[c] = decay(longint'(top - longint'(logits[c])));
      total += ex[c];
    end
    for (int c = 0; c < CLASSES; c++) begin
      prob[c] = ((ex[c] << 16) + total / 2) / total;
      if (prob[c] > 65535) prob[c] = 65535;
      if (prob[c] > prob[winner]) winner = c;
    end
    for (int c = 0; c < CLASSES; c++) begin
      r.class_id        = 4'(c);
      r.logit           = logits[c];
      r.probability     = 16'(prob[c]);
      r.predicted_class = 4'(winner);
      r.last_result     = (c == CLASSES - 1);
      results_due.push_back(r);
      class_sums[c] = '0;
    end
  endtask

  task automatic absorb(input in_item_t it);
    case (it.opcode)
      OP_WEIGHT: begin
        if (it.class_index < CLASSES && it.pixel_index < PIXELS)
          weights[it.class_index][it.pixel_index] = it.coef_value;
      end
      OP_BIAS: begin
        if (it.class_index < CLASSES) biases[it.class_index] = it.bias_value;
      end
      OP_PIXEL: begin
        if (it.pixel_index < PIXELS)
          for (int c = 0; c < CLASSES; c++)
            class_sums[c] = clip40(longint'(class_sums[c]) +
              longint'(weights[c][it.pixel_index]) * longint'({1'b0, it.pixel_value}));
        if (it.last_pixel) close_image();
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      for (int c = 0; c < CLASSES; c++) class_sums[c] <= '0;
      results_due.delete();
      errors <= 0;
      outstanding <= 0;
    end else begin
      if (pop && !empty) begin
        if (results_due.size() == 0) begin
          if (errors < 10) $display("unexpected result item: %p", out_item);
          errors <= errors + 1;
        end else begin
          want = results_due.pop_front();
          if (out_item !== want) begin
            if (errors < 10)
              $display("result mismatch: expected %p, actual %p", want, out_item);
            errors <= errors + 1;
          end
        end
      end
      if (push && !full) absorb(in_item);
      outstanding <= results_due.size();
    end
  end

endmodule

/* bench/linear_softmax_classifier_core_test.sv */
`timescale 1ns / 100ps
// Top of the classifier testbench: clock, reset, input and output traffic.
// Depends on lsc_pkg, linear_softmax_classifier_core and lsc_result_checker.
module linear_softmax_classifier_core_test;
  import lsc_pkg::*;

  // The fourth opcode value has no meaning and must be dropped by the block.
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 600000;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  in_item_t  in_item = '0;
  logic      push = 1'b0;
  logic      full;
  out_item_t out_item;
  logic      empty;
  logic      pop = 1'b0;
  int        errors;
  int        outstanding;
  int        cycles = 0;

  // Only these pixels ever get weights for every class, so a pixel item
  // never reads a weight that was never written. Pixel items outside the
  // image read no weight at all and are always safe.
  int unsigned loaded_pix [4] = '{0, 1, 2, 783};

  // While a burst flag is set the matching side never idles.
  bit push_burst = 1'b0;
  bit pop_burst  = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  linear_softmax_classifier_core dut (
    .clk(clk), .rst(rst), .in_item(in_item), .push(push), .full(full),
    .out_item(out_item), .empty(empty), .pop(pop)
  );

  lsc_result_checker u_checker (
    .clk(clk), .rst(rst), .in_item(in_item), .push(push), .full(full),
    .out_item(out_item), .empty(empty), .pop(pop),
    .errors(errors), .outstanding(outstanding)
  );

  // A cycle counter guards against a hung block.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic in_item_t make_item(input logic [1:0] op, input logic [3:0] cls,
                                         input logic [9:0] pix, input logic [15:0] coef,
                                         input logic [31:0] bias, input logic [7:0] pv,
                                         input logic last);
    in_item_t it;
    it.opcode      = op;
    it.class_index = cls;
    it.pixel_index = pix;
    it.coef_value  = coef;
    it.bias_value  = bias;
    it.pixel_value = pv;
    it.last_pixel  = last;
    return it;
  endfunction

  // Offers one item and returns once the block has taken it. Push is only
  // lowered during an idle gap, so back-to-back items keep it high.
  task automatic offer(input in_item_t it);
    int gap;
    gap = push_burst ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      push <= 1'b0;
      in_item <= in_item_t'({$urandom, $urandom, $urandom});
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (full);
  endtask

  // The receiving side: a random stall before each result, sometimes none.
  initial begin
    int stall;
    @(negedge rst);
    forever begin
      if ($urandom_range(0, 29) == 0) pop_burst = ~pop_burst;
      stall = pop_burst ? 0 : $urandom_range(0, 13);
      if (stall > 0) begin
        pop <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
    end
  end

  initial begin
    logic [1:0]  op;
    logic [3:0]  cls;
    logic [9:0]  pix;
    logic [31:0] bias;
    int          pick;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Load every bias and every weight that pixel items will read. With
    // all of them zero the first image is a ten-way tie, so class zero wins.
    for (int c = 0; c < 10; c++) begin
      offer(make_item(OP_BIAS, 4'(c), 10'd0, 16'd0, 32'd0, 8'd0, 1'b0));
      foreach (loaded_pix[i])
        offer(make_item(OP_WEIGHT, 4'(c), 10'(loaded_pix[i]), 16'd0, 32'd0, 8'd0, 1'b0));
    end
    offer(make_item(OP_PIXEL, 4'd0, 10'd0, 16'd0, 32'd0, 8'd255, 1'b1));

    // Directed part: extreme weights and biases, writes that must be
    // ignored, an unused opcode carrying the last mark, and an image that
    // finishes on a pixel outside the image.
    offer(make_item(OP_WEIGHT, 4'd3, 10'd0, 16'h7FFF, 32'd0, 8'd0, 1'b0));
    offer(make_item(OP_WEIGHT, 4'd4, 10'd0, 16'h8000, 32'd0, 8'd0, 1'b0));
    offer(make_item(OP_WEIGHT, 4'd0, 10'd1, 16'hFFFF, 32'd0, 8'd0, 1'b0));
    offer(make_item(OP_WEIGHT, 4'd15, 10'd0, 16'h1234, 32'd0, 8'd0, 1'b0));
    offer(make_item(OP_WEIGHT, 4'd2, 10'd1023, 16'h4321, 32'd0, 8'd0, 1'b0));
    offer(make_item(OP_BIAS, 4'd12, 10'd0, 16'd0, 32'h7FFF_FFFF, 8'd0, 1'b0));
    offer(make_item(OP_UNUSED, 4'd1, 10'd0, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF, 1'b1));
    offer(make_item(OP_PIXEL, 4'd0, 10'd0, 16'd0, 32'd0, 8'd255, 1'b0));
    offer(make_item(OP_PIXEL, 4'd0, 10'd1, 16'd0, 32'd0, 8'd0, 1'b0));
    offer(make_item(OP_PIXEL, 4'd0, 10'd900, 16'd0, 32'd0, 8'd255, 1'b1));
    // Huge bias gaps drive most exponentials to zero.
    offer(make_item(OP_BIAS, 4'd9, 10'd0, 16'd0, 32'h7FFF_FFFF, 8'd0, 1'b0));
    offer(make_item(OP_BIAS, 4'd8, 10'd0, 16'd0, 32'h8000_0000, 8'd0, 1'b0));
    offer(make_item(OP_PIXEL, 4'd0, 10'd783, 16'd0, 32'd0, 8'd128, 1'b1));
    offer(make_item(OP_PIXEL, 4'd0, 10'd1023, 16'd0, 32'd0, 8'd1, 1'b1));

    // Random part: mostly pixel streams over loaded pixels with frequent
    // image ends, mixed with weight and bias updates and some noise.
    for (int n = 0; n < 185; n++) begin
      if ($urandom_range(0, 29) == 0) push_burst = ~push_burst;
      pick = $urandom_range(0, 99);
      cls = 4'($urandom_range(0, 9));
      pix = 10'(loaded_pix[$urandom_range(0, 3)]);
      bias = $urandom_range(0, 1) ? $urandom : 32'($urandom_range(0, 4000000)) - 32'd2000000;
      if (pick < 12) begin
        op = OP_WEIGHT;
        if ($urandom_range(0, 5) == 0) cls = 4'($urandom_range(10, 15));
        if ($urandom_range(0, 5) == 0) pix = 10'($urandom_range(784, 1023));
      end else if (pick < 20) begin
        op = OP_BIAS;
        if ($urandom_range(0, 5) == 0) cls = 4'($urandom_range(10, 15));
      end else if (pick < 24) begin
        op = OP_UNUSED;
        cls = 4'($urandom);
        pix = 10'($urandom);
      end else begin
        op = OP_PIXEL;
        if ($urandom_range(0, 7) == 0) pix = 10'($urandom_range(784, 1023));
      end
      offer(make_item(op, cls, pix, 16'($urandom), bias, 8'($urandom),
                      $urandom_range(0, 5) == 0));
    end
    // Close whatever image is still open.
    offer(make_item(OP_PIXEL, 4'd0, 10'd2, 16'd0, 32'd0, 8'd77, 1'b1));
    push <= 1'b0;

    // Let the checker count the results of the final item before waiting.
    repeat (2) @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (500) @(posedge clk);
    if (errors == 0 && outstanding == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/lsc_pkg.sv
hdl/lsc_front.sv
hdl/lsc_divider.sv
hdl/lsc_back.sv
hdl/linear_softmax_classifier_core.sv
bench/lsc_result_checker.sv
bench/linear_softmax_classifier_core_test.sv
